/* rtl/core/bhq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned STS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DEL_LD,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/bhq_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bhq_req_if #(
  parameter int unsigned TAG_BITS = 8
);
  import bhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic [TAG_BITS-1:0]     tag;

  modport source (output valid, output op, output key, output tag, input ready);
  modport sink (input valid, input op, input key, input tag, output ready);
endinterface

interface bhq_rsp_if #(
  parameter int unsigned TAG_BITS = 8,
  parameter int unsigned CNT_W    = 7
);
  import bhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] min_key;
  logic [TAG_BITS-1:0]     min_tag;
  status_e                 status;
  logic [CNT_W-1:0]        occupancy;

  modport source (
    output valid, output min_key, output min_tag, output status, output occupancy,
    input ready
  );
  modport sink (
    input valid, input min_key, input min_tag, input status, input occupancy,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/bhq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bhq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/core/binary_min_heap_queue.sv */
// Channel | Dir | Handshake     | Word
// req_i   | in  | valid / ready | op, key, tag
// rsp_o   | out | valid / ready | min_key, min_tag, status, occupancy
//
// One word at a time. Insert sifts the new entry up U levels from the new last slot;
// delete takes the root and sifts the last entry down D levels from the root.
// Each level costs a read of the entry store and a compare-and-write step.
// Insert on full or delete on empty goes straight to the result without a store access.
// Reset clears count and control only; the store needs no clearing pass.
// A stalled rsp_o holds the result register, and with it the next accept.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned TAG_BITS = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  bhq_req_if.sink   req_i,
  bhq_rsp_if.source rsp_o
);
  import bhq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CHD_W = CNT_W + 1;
  localparam int unsigned ENT_W = KEY_W + TAG_BITS;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  logic signed [KEY_W-1:0] mov_key_q, mov_key_d;
  logic [TAG_BITS-1:0]     mov_tag_q, mov_tag_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  logic [TAG_BITS-1:0]     res_tag_q, res_tag_d;
  status_e                 res_sts_q, res_sts_d;

  logic                    ov_q;
  logic signed [KEY_W-1:0] okey_q;
  logic [TAG_BITS-1:0]     otag_q;
  status_e                 osts_q;
  logic [CNT_W-1:0]        oocc_q;
  logic                    load_out;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  logic [ENT_W-1:0] wdata, rdata_a, rdata_b;

  logic signed [KEY_W-1:0] rda_key, rdb_key, pick_key;
  logic [TAG_BITS-1:0]     rda_tag, rdb_tag, pick_tag;
  logic                    pick_r;

  logic [CNT_W-1:0] slot_m1, parent, parent_m1, last_m1;
  logic [CHD_W-1:0] child_l, child_r, child_lm1, cnt_ext;

  assign rda_key = rdata_a[ENT_W-1:TAG_BITS];
  assign rda_tag = rdata_a[TAG_BITS-1:0];
  assign rdb_key = rdata_b[ENT_W-1:TAG_BITS];
  assign rdb_tag = rdata_b[TAG_BITS-1:0];

  assign slot_m1   = slot_q - OneCnt;
  assign parent    = slot_q >> 1;
  assign parent_m1 = parent - OneCnt;
  assign last_m1   = cnt_q - OneCnt;
  assign child_l   = {slot_q, 1'b0};
  assign child_r   = {slot_q, 1'b1};
  assign child_lm1 = child_l - CHD_W'(1);
  assign cnt_ext   = {1'b0, cnt_q};

  // right child wins only when present and strictly smaller
  assign pick_r   = (child_r <= cnt_ext) && (rdb_key < rda_key);
  assign pick_key = pick_r ? rdb_key : rda_key;
  assign pick_tag = pick_r ? rdb_tag : rda_tag;

  bhq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_bhq_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    mov_key_d   = mov_key_q;
    mov_tag_d   = mov_tag_q;
    res_key_d   = res_key_q;
    res_tag_d   = res_tag_q;
    res_sts_d   = res_sts_q;
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    we          = 1'b0;
    waddr       = slot_m1[IDX_W-1:0];
    wdata       = {mov_key_q, mov_tag_q};
    raddr_a     = '0;
    raddr_b     = '0;

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          res_key_d = '0;
          res_tag_d = '0;
          res_sts_d = STS_OK;
          if (req_i.op == OP_INSERT) begin
            if (cnt_q == CapCnt) begin
              res_sts_d = STS_FULL;
              state_d   = ST_EMIT;
            end else begin
              mov_key_d = req_i.key;
              mov_tag_d = req_i.tag;
              cnt_d     = cnt_q + OneCnt;
              slot_d    = cnt_q + OneCnt;
              state_d   = ST_UP_CHK;
            end
          end else if (cnt_q == '0) begin
            res_sts_d = STS_EMPTY;
            state_d   = ST_EMIT;
          end else begin
            // fetch root and last entry together
            raddr_b = last_m1[IDX_W-1:0];
            state_d = ST_DEL_LD;
          end
        end
      end
      ST_UP_CHK: begin
        if (slot_q == OneCnt) begin
          we      = 1'b1;
          state_d = ST_EMIT;
        end else begin
          raddr_a = parent_m1[IDX_W-1:0];
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (mov_key_q < rda_key) begin
          // move parent down into the hole, climb one level
          wdata   = rdata_a;
          slot_d  = parent;
          state_d = ST_UP_CHK;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DEL_LD: begin
        res_key_d = rda_key;
        res_tag_d = rda_tag;
        mov_key_d = rdb_key;
        mov_tag_d = rdb_tag;
        cnt_d     = last_m1;
        slot_d    = OneCnt;
        state_d   = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (child_l > cnt_ext) begin
          we      = 1'b1;
          state_d = ST_EMIT;
        end else begin
          raddr_a = child_lm1[IDX_W-1:0];
          raddr_b = child_l[IDX_W-1:0];
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (pick_key < mov_key_q) begin
          // lift the smaller child into the hole, descend
          wdata   = {pick_key, pick_tag};
          slot_d  = pick_r ? child_r[CNT_W-1:0] : child_l[CNT_W-1:0];
          state_d = ST_DN_CHK;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    mov_key_q <= mov_key_d;
    mov_tag_q <= mov_tag_d;
    res_key_q <= res_key_d;
    res_tag_q <= res_tag_d;
    res_sts_q <= res_sts_d;
    if (load_out) begin
      okey_q <= res_key_q;
      otag_q <= res_tag_q;
      osts_q <= res_sts_q;
      oocc_q <= cnt_q;
    end
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.min_key   = okey_q;
  assign rsp_o.min_tag   = otag_q;
  assign rsp_o.status    = osts_q;
  assign rsp_o.occupancy = oocc_q;

endmodule

`default_nettype wire

/* rtl/core/bhq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bhq_checker #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned TAG_BITS = 8,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           req_valid_i,
  input wire logic                           req_ready_i,
  input wire logic                           rsp_valid_i,
  input wire logic                           rsp_ready_i,
  input wire logic signed [bhq_pkg::KEY_W-1:0] rsp_min_key_i,
  input wire logic [TAG_BITS-1:0]            rsp_min_tag_i,
  input wire logic [bhq_pkg::STS_W-1:0]      rsp_status_i,
  input wire logic [CNT_W-1:0]               rsp_occupancy_i
);
  import bhq_pkg::*;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_min_key_i)
      && $stable(rsp_min_tag_i) && $stable(rsp_status_i) && $stable(rsp_occupancy_i))
    else $error("bhq: result word changed under stall");

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("bhq: request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STS_FULL) |-> rsp_occupancy_i == CapCnt)
    else $error("bhq: full status with spare room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STS_EMPTY)
      |-> (rsp_occupancy_i == '0) && (rsp_min_key_i == '0) && (rsp_min_tag_i == '0))
    else $error("bhq: empty status with entries or data");

endmodule

bind binary_min_heap_queue bhq_checker #(
  .CAPACITY (CAPACITY),
  .TAG_BITS (TAG_BITS)
) u_bhq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_min_key_i   (rsp_o.min_key),
  .rsp_min_tag_i   (rsp_o.min_tag),
  .rsp_status_i    (rsp_o.status),
  .rsp_occupancy_i (rsp_o.occupancy)
);

`default_nettype wire
